/* rtl/rvs_pkg.sv */
// ---------------------------------------------------------------------------
// rvs_pkg
// Shared types and constants for the reading value stabilizer.
// ---------------------------------------------------------------------------
package rvs_pkg;

    // field widths
    localparam int TIME_W  = 32;
    localparam int VALUE_W = 32;
    localparam int CONF_W  = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int SETTLE_W   = 16;
    localparam int BEAT_W     = 20;
    localparam int FRESH_W    = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRESH_MS     = 2'd2;

    // register reset values
    localparam logic [SETTLE_W-1:0] SETTLE_RST = 16'd300;
    localparam logic [BEAT_W-1:0]   BEAT_RST   = 20'd10000;
    localparam logic [FRESH_W-1:0]  FRESH_RST  = 16'd3000;

    // event kinds
    localparam logic KIND_BALANCE = 1'b0;
    localparam logic KIND_DELTA   = 1'b1;

    // result queue
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // one settling candidate
    typedef struct packed {
        logic                      set;
        logic signed [VALUE_W-1:0] value;
        logic [TIME_W-1:0]         first;
        logic [CONF_W-1:0]         conf;
    } t_cand;

    // one result item
    typedef struct packed {
        logic                      kind;
        logic                      is_heartbeat;
        logic [TIME_W-1:0]         time_ms;
        logic signed [VALUE_W-1:0] value;
        logic [CONF_W-1:0]         conf;
        logic                      last_of_run;
    } t_event;

endpackage

/* rtl/rvs_frame_if.sv */
// ---------------------------------------------------------------------------
// rvs_frame_if
// Valid/ready channel carrying one timestamped frame with two readings.
// ---------------------------------------------------------------------------
interface rvs_frame_if;
    logic                                     valid;
    logic                                     ready;
    logic [rvs_pkg::TIME_W-1:0]               time_ms;
    logic                                     bal_valid;
    logic signed [rvs_pkg::VALUE_W-1:0]       bal_value;
    logic [rvs_pkg::CONF_W-1:0]               bal_conf;
    logic                                     dlt_valid;
    logic signed [rvs_pkg::VALUE_W-1:0]       dlt_value;
    logic [rvs_pkg::CONF_W-1:0]               dlt_conf;

    modport source (
        output valid, time_ms, bal_valid, bal_value, bal_conf,
               dlt_valid, dlt_value, dlt_conf,
        input  ready
    );
    modport sink (
        input  valid, time_ms, bal_valid, bal_value, bal_conf,
               dlt_valid, dlt_value, dlt_conf,
        output ready
    );
endinterface

/* rtl/rvs_event_if.sv */
// ---------------------------------------------------------------------------
// rvs_event_if
// Valid/ready channel carrying one balance or delta report.
// ---------------------------------------------------------------------------
interface rvs_event_if;
    logic                               valid;
    logic                               ready;
    logic                               event_kind;
    logic                               is_heartbeat;
    logic [rvs_pkg::TIME_W-1:0]         event_time;
    logic signed [rvs_pkg::VALUE_W-1:0] event_value;
    logic [rvs_pkg::CONF_W-1:0]         event_conf;
    logic                               last_of_run;

    modport source (
        output valid, event_kind, is_heartbeat, event_time, event_value,
               event_conf, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, event_kind, is_heartbeat, event_time, event_value,
               event_conf, last_of_run,
        output ready
    );
endinterface

/* rtl/reading_value_stabilizer_top.sv */
// ---------------------------------------------------------------------------
// reading_value_stabilizer_top
// Settles per-frame balance and delta readings and reports stable values,
// with a periodic heartbeat of a fresh stable balance.
// ---------------------------------------------------------------------------
//  channel   dir  handshake      carries
//  i_frame   in   valid/ready    time, balance reading, delta reading
//  o_event   out  valid/ready    one report (kind, heartbeat, time, value, conf)
//  i_cfg_*   in   write enable   settle_ms, heartbeat_ms, fresh_ms
//
//  A frame is captured in the input register and processed once the 4-entry
//  result queue has room for two results; it then yields 0..2 reports, one
//  leaving per cycle while o_event is ready. A new frame can enter as the held
//  one is processed; two-report frames are held back by the single output
//  transfer per cycle. Reset clears the queue and tracking state and loads
//  register reset values. A stall on o_event fills the queue, then holds off i_frame.
// ---------------------------------------------------------------------------
module reading_value_stabilizer_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rvs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rvs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    rvs_frame_if.sink                            i_frame,
    rvs_event_if.source                          o_event
);
    import rvs_pkg::*;

    // configuration registers
    logic [SETTLE_W-1:0] r_settle_ms;
    logic [BEAT_W-1:0]   r_heartbeat_ms;
    logic [FRESH_W-1:0]  r_fresh_ms;

    // input register
    logic                      r_in_vld;
    logic [TIME_W-1:0]         r_time;
    logic                      r_bal_vld;
    logic signed [VALUE_W-1:0] r_bal_value;
    logic [CONF_W-1:0]         r_bal_conf;
    logic                      r_dlt_vld;
    logic signed [VALUE_W-1:0] r_dlt_value;
    logic [CONF_W-1:0]         r_dlt_conf;

    // tracking state
    t_cand                     r_bal_cand, n_bal_cand;
    t_cand                     r_dlt_cand, n_dlt_cand;
    logic signed [VALUE_W-1:0] r_stable_bal, n_stable_bal;
    logic [TIME_W-1:0]         r_stable_seen, n_stable_seen;
    logic                      r_has_stable, n_has_stable;
    logic signed [VALUE_W-1:0] r_rep_bal, n_rep_bal;
    logic [TIME_W-1:0]         r_last_beat, n_last_beat;
    logic signed [VALUE_W-1:0] r_rep_dlt, n_rep_dlt;
    logic                      r_dlt_once, n_dlt_once;

    // result queue
    t_event                    r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]        r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]          r_cnt;

    logic                      fire, pop, accept;
    logic [FIFO_AW:0]          cnt_after_pop;
    logic                      bal_match, bal_settled, dlt_match, dlt_settled;
    logic                      bal_change, beat, dlt_report;
    logic [TIME_W-1:0]         bal_span, dlt_span, fresh_age, beat_age;
    t_event                    ev_a, ev_b;
    logic                      ev_a_vld, ev_b_vld;
    logic [FIFO_AW-1:0]        ptr_b;
    logic [FIFO_AW:0]          push_n;

    // handshakes
    assign pop           = o_event.valid && o_event.ready;
    assign cnt_after_pop = r_cnt - (FIFO_AW+1)'(pop);
    assign fire          = r_in_vld && (cnt_after_pop <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign i_frame.ready = !r_in_vld || fire;
    assign accept        = i_frame.valid && i_frame.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ms    <= SETTLE_RST;
            r_heartbeat_ms <= BEAT_RST;
            r_fresh_ms     <= FRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SETTLE_MS:    r_settle_ms    <= i_cfg_data[SETTLE_W-1:0];
                CFG_HEARTBEAT_MS: r_heartbeat_ms <= i_cfg_data[BEAT_W-1:0];
                CFG_FRESH_MS:     r_fresh_ms     <= i_cfg_data[FRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_time      <= i_frame.time_ms;
            r_bal_vld   <= i_frame.bal_valid;
            r_bal_value <= i_frame.bal_value;
            r_bal_conf  <= i_frame.bal_conf;
            r_dlt_vld   <= i_frame.dlt_valid;
            r_dlt_value <= i_frame.dlt_value;
            r_dlt_conf  <= i_frame.dlt_conf;
        end
    end

    // balance candidate: a match settles once the span reaches settle_ms
    assign bal_match   = r_bal_cand.set && (r_bal_cand.value == r_bal_value);
    assign bal_span    = r_time - r_bal_cand.first;
    assign bal_settled = r_bal_vld && bal_match
                      && (bal_span >= {{(TIME_W-SETTLE_W){1'b0}}, r_settle_ms});

    always_comb begin
        n_bal_cand = r_bal_cand;
        if (r_bal_vld) begin
            if (bal_match) begin
                if (r_bal_conf < r_bal_cand.conf) begin
                    n_bal_cand.conf = r_bal_conf;
                end
            end else begin
                n_bal_cand.set   = 1'b1;
                n_bal_cand.value = r_bal_value;
                n_bal_cand.first = r_time;
                n_bal_cand.conf  = r_bal_conf;
            end
        end
    end

    // delta candidate
    assign dlt_match   = r_dlt_cand.set && (r_dlt_cand.value == r_dlt_value);
    assign dlt_span    = r_time - r_dlt_cand.first;
    assign dlt_settled = r_dlt_vld && dlt_match
                      && (dlt_span >= {{(TIME_W-SETTLE_W){1'b0}}, r_settle_ms});

    always_comb begin
        n_dlt_cand = r_dlt_cand;
        if (r_dlt_vld) begin
            if (dlt_match) begin
                if (r_dlt_conf < r_dlt_cand.conf) begin
                    n_dlt_cand.conf = r_dlt_conf;
                end
            end else begin
                n_dlt_cand.set   = 1'b1;
                n_dlt_cand.value = r_dlt_value;
                n_dlt_cand.first = r_time;
                n_dlt_cand.conf  = r_dlt_conf;
            end
        end
    end

    // balance reporting and heartbeat
    assign n_stable_bal  = bal_settled ? r_bal_cand.value : r_stable_bal;
    assign n_stable_seen = bal_settled ? r_time : r_stable_seen;
    assign n_has_stable  = bal_settled || r_has_stable;
    assign bal_change    = bal_settled && (r_bal_cand.value != r_rep_bal);
    assign fresh_age     = r_time - n_stable_seen;
    assign beat_age      = r_time - r_last_beat;
    assign beat = !bal_change && n_has_stable
               && (fresh_age <= {{(TIME_W-FRESH_W){1'b0}}, r_fresh_ms})
               && (beat_age >= {{(TIME_W-BEAT_W){1'b0}}, r_heartbeat_ms});
    assign n_rep_bal   = bal_change ? r_bal_cand.value : r_rep_bal;
    assign n_last_beat = (bal_change || beat) ? r_time : r_last_beat;

    // delta reporting
    assign dlt_report = dlt_settled && (!r_dlt_once || (r_dlt_cand.value != r_rep_dlt));
    assign n_rep_dlt  = dlt_report ? r_dlt_cand.value : r_rep_dlt;
    assign n_dlt_once = dlt_report || r_dlt_once;

    // results of this frame: balance slot first, then delta slot
    assign ev_a_vld = bal_change || beat;
    assign ev_b_vld = dlt_report;

    always_comb begin
        ev_a.kind         = KIND_BALANCE;
        ev_a.is_heartbeat = !bal_change;
        ev_a.time_ms      = bal_change ? r_bal_cand.first : r_time;
        ev_a.value        = n_stable_bal;
        ev_a.conf         = n_bal_cand.conf;
        ev_a.last_of_run  = !ev_b_vld;

        ev_b.kind         = KIND_DELTA;
        ev_b.is_heartbeat = 1'b0;
        ev_b.time_ms      = r_dlt_cand.first;
        ev_b.value        = r_dlt_cand.value;
        ev_b.conf         = n_dlt_cand.conf;
        ev_b.last_of_run  = 1'b1;
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal_cand    <= '0;
            r_dlt_cand    <= '0;
            r_stable_bal  <= '0;
            r_stable_seen <= '0;
            r_has_stable  <= 1'b0;
            r_rep_bal     <= '0;
            r_last_beat   <= '0;
            r_rep_dlt     <= '0;
            r_dlt_once    <= 1'b0;
        end else if (fire) begin
            r_bal_cand    <= n_bal_cand;
            r_dlt_cand    <= n_dlt_cand;
            r_stable_bal  <= n_stable_bal;
            r_stable_seen <= n_stable_seen;
            r_has_stable  <= n_has_stable;
            r_rep_bal     <= n_rep_bal;
            r_last_beat   <= n_last_beat;
            r_rep_dlt     <= n_rep_dlt;
            r_dlt_once    <= n_dlt_once;
        end
    end

    // result queue: up to two writes and, when o_event takes one, one read per cycle
    assign ptr_b  = r_wr_ptr + FIFO_AW'(ev_a_vld);
    assign push_n = fire ? ((FIFO_AW+1)'(ev_a_vld) + (FIFO_AW+1)'(ev_b_vld))
                         : '0;

    always_ff @(posedge i_clk) begin
        if (fire && ev_a_vld) begin
            r_fifo[r_wr_ptr] <= ev_a;
        end
        if (fire && ev_b_vld) begin
            r_fifo[ptr_b] <= ev_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[FIFO_AW-1:0];
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(pop);
            r_cnt    <= cnt_after_pop + push_n;
        end
    end

    // output side
    assign o_event.valid        = (r_cnt != '0);
    assign o_event.event_kind   = r_fifo[r_rd_ptr].kind;
    assign o_event.is_heartbeat = r_fifo[r_rd_ptr].is_heartbeat;
    assign o_event.event_time   = r_fifo[r_rd_ptr].time_ms;
    assign o_event.event_value  = r_fifo[r_rd_ptr].value;
    assign o_event.event_conf   = r_fifo[r_rd_ptr].conf;
    assign o_event.last_of_run  = r_fifo[r_rd_ptr].last_of_run;

endmodule

/* sim/reading_value_stabilizer_top_test.sv */
// ---------------------------------------------------------------------------
// reading_value_stabilizer_top_test
// Sends timestamped balance/delta frames to the stabilizer with random source
// gaps and sink stalls. A scoreboard predicts every balance, heartbeat and
// delta report and checks the reports in order, field by field. The run
// covers the reset register values and several other settings, extremes
// among them.
// ---------------------------------------------------------------------------
module reading_value_stabilizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rvs_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;

    // one frame as the source sends it
    typedef struct {
        logic [TIME_W-1:0]         time_ms;
        logic                      bal_valid;
        logic signed [VALUE_W-1:0] bal_value;
        logic [CONF_W-1:0]         bal_conf;
        logic                      dlt_valid;
        logic signed [VALUE_W-1:0] dlt_value;
        logic [CONF_W-1:0]         dlt_conf;
    } t_frame;

    // run of identical readings that may settle
    typedef struct {
        bit                 held;
        logic [VALUE_W-1:0] value;
        logic [TIME_W-1:0]  first_ms;
        logic [TIME_W-1:0]  last_ms;
        logic [1:0]         hits;
        logic [CONF_W-1:0]  min_conf;
    } t_reading_run;

    // -----------------------------------------------------------------------
    // Report scoreboard: settling state, register copies, pending reports
    // -----------------------------------------------------------------------
    class t_report_scoreboard;
        logic [SETTLE_W-1:0] settle_ms;
        logic [BEAT_W-1:0]   heartbeat_ms;
        logic [FRESH_W-1:0]  fresh_ms;
        t_reading_run        bal_run;
        t_reading_run        dlt_run;
        logic [VALUE_W-1:0]  stable_balance;
        logic [TIME_W-1:0]   stable_seen_ms;
        bit                  has_stable;
        logic [VALUE_W-1:0]  reported_balance;
        logic [TIME_W-1:0]   last_beat_ms;
        logic [VALUE_W-1:0]  reported_delta;
        bit                  delta_sent;
        t_event              pending_reports[$];
        int                  mismatches;

        function new();
            settle_ms        = SETTLE_RST;
            heartbeat_ms     = BEAT_RST;
            fresh_ms         = FRESH_RST;
            bal_run          = '{default: '0};
            dlt_run          = '{default: '0};
            stable_balance   = '0;
            stable_seen_ms   = '0;
            has_stable       = 1'b0;
            reported_balance = '0;
            last_beat_ms     = '0;
            reported_delta   = '0;
            delta_sent       = 1'b0;
            mismatches       = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SETTLE_MS:    settle_ms    = data[SETTLE_W-1:0];
                CFG_HEARTBEAT_MS: heartbeat_ms = data[BEAT_W-1:0];
                CFG_FRESH_MS:     fresh_ms     = data[FRESH_W-1:0];
                default: ;
            endcase
        endfunction

        // extend or restart a run; 1 once two hits span at least settle_ms
        function bit extend_run(inout t_reading_run run, input logic [TIME_W-1:0] t,
                                input logic [VALUE_W-1:0] v, input logic [CONF_W-1:0] c);
            logic [TIME_W-1:0] span;
            if (run.held && run.value == v) begin
                if (run.hits != 2'd3) run.hits = run.hits + 2'd1;
                run.last_ms = t;
                if (c < run.min_conf) run.min_conf = c;
            end else begin
                run.held     = 1'b1;
                run.value    = v;
                run.first_ms = t;
                run.last_ms  = t;
                run.hits     = 2'd1;
                run.min_conf = c;
            end
            span = run.last_ms - run.first_ms;
            return run.hits >= 2'd2 && span >= TIME_W'(settle_ms);
        endfunction

        function void push_report(logic kind, logic beat, logic [TIME_W-1:0] t,
                                  logic [VALUE_W-1:0] v, logic [CONF_W-1:0] c);
            t_event ev;
            ev.kind         = kind;
            ev.is_heartbeat = beat;
            ev.time_ms      = t;
            ev.value        = v;
            ev.conf         = c;
            ev.last_of_run  = 1'b0;
            pending_reports.insert(pending_reports.size(), ev);
        endfunction

        // work out the reports one accepted frame causes
        function void note_frame(t_frame f);
            logic [TIME_W-1:0] t;
            logic [TIME_W-1:0] since_settle;
            logic [TIME_W-1:0] since_beat;
            bit                changed;
            int                n;
            t       = f.time_ms;
            changed = 1'b0;
            n       = 0;

            if (f.bal_valid && extend_run(bal_run, t, f.bal_value, f.bal_conf)) begin
                stable_balance = bal_run.value;
                stable_seen_ms = t;
                has_stable     = 1'b1;
                if (stable_balance != reported_balance) begin
                    push_report(KIND_BALANCE, 1'b0, bal_run.first_ms, stable_balance,
                                bal_run.min_conf);
                    reported_balance = stable_balance;
                    last_beat_ms     = t;
                    changed          = 1'b1;
                    n++;
                end
            end

            // heartbeat of a fresh stable balance, never beside a change report
            since_settle = t - stable_seen_ms;
            since_beat   = t - last_beat_ms;
            if (!changed && has_stable && since_settle <= TIME_W'(fresh_ms) &&
                since_beat >= TIME_W'(heartbeat_ms)) begin
                push_report(KIND_BALANCE, 1'b1, t, stable_balance, bal_run.min_conf);
                last_beat_ms = t;
                n++;
            end

            if (f.dlt_valid && extend_run(dlt_run, t, f.dlt_value, f.dlt_conf)) begin
                if (!delta_sent || dlt_run.value != reported_delta) begin
                    push_report(KIND_DELTA, 1'b0, dlt_run.first_ms, dlt_run.value,
                                dlt_run.min_conf);
                    reported_delta = dlt_run.value;
                    delta_sent     = 1'b1;
                    n++;
                end
            end

            if (n > 0) pending_reports[pending_reports.size()-1].last_of_run = 1'b1;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, what);
        endtask

        task check_event(t_event got);
            t_event want;
            if (pending_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected report kind=%0d value=%0d",
                                          got.kind, got.value));
                return;
            end
            want = pending_reports.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("event_kind %0d, want %0d", got.kind, want.kind));
            if (got.is_heartbeat !== want.is_heartbeat)
                report_mismatch($sformatf("is_heartbeat %0d, want %0d",
                                          got.is_heartbeat, want.is_heartbeat));
            if (got.time_ms !== want.time_ms)
                report_mismatch($sformatf("event_time %0h, want %0h",
                                          got.time_ms, want.time_ms));
            if (got.value !== want.value)
                report_mismatch($sformatf("event_value %0d, want %0d", got.value, want.value));
            if (got.conf !== want.conf)
                report_mismatch($sformatf("event_conf %0d, want %0d", got.conf, want.conf));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %0d, want %0d",
                                          got.last_of_run, want.last_of_run));
        endtask
    endclass

    // -----------------------------------------------------------------------
    // Block under test
    // -----------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rvs_frame_if frame_bus();
    rvs_event_if report_bus();

    reading_value_stabilizer_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_frame    (frame_bus),
        .o_event    (report_bus)
    );

    t_report_scoreboard ledger;
    logic [TIME_W-1:0]  frame_clock;
    logic [VALUE_W-1:0] bal_target;
    logic [VALUE_W-1:0] dlt_target;
    int                 sender_calm;
    int                 sink_calm;
    int                 cycle_count;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // idle cycles before a transfer; now and then a stretch with none
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // readings: a few small values, the extremes, or anything
    function automatic logic [VALUE_W-1:0] pick_reading();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_frame compose_frame(logic [TIME_W-1:0] t, logic bv,
                                             logic [VALUE_W-1:0] bval, logic [CONF_W-1:0] bconf,
                                             logic dv, logic [VALUE_W-1:0] dval,
                                             logic [CONF_W-1:0] dconf);
        t_frame f;
        f.time_ms   = t;
        f.bal_valid = bv;
        f.bal_value = bval;
        f.bal_conf  = bconf;
        f.dlt_valid = dv;
        f.dlt_value = dval;
        f.dlt_conf  = dconf;
        return f;
    endfunction

    // one frame transfer; valid stays high when the next frame follows at once
    task automatic send_frame(input t_frame f);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0) begin
            frame_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frame_bus.valid     <= 1'b1;
        frame_bus.time_ms   <= f.time_ms;
        frame_bus.bal_valid <= f.bal_valid;
        frame_bus.bal_value <= f.bal_value;
        frame_bus.bal_conf  <= f.bal_conf;
        frame_bus.dlt_valid <= f.dlt_valid;
        frame_bus.dlt_value <= f.dlt_value;
        frame_bus.dlt_conf  <= f.dlt_conf;
        do @(posedge i_clk); while (frame_bus.ready !== 1'b1);
        ledger.note_frame(f);
    endtask

    // hold the source until every pending report has come, then let it settle
    task automatic wait_for_drain();
        frame_bus.valid <= 1'b0;
        while (ledger.pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(input int settle, input int beat, input int fresh);
        logic [CFG_DATA_W-1:0] data [3];
        logic [CFG_IDX_W-1:0]  idx [3];
        data = '{CFG_DATA_W'(settle), CFG_DATA_W'(beat), CFG_DATA_W'(fresh)};
        idx  = '{CFG_SETTLE_MS, CFG_HEARTBEAT_MS, CFG_FRESH_MS};
        foreach (idx[k]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= data[k];
            @(posedge i_clk);
            ledger.set_register(idx[k], data[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // directed frames at the reset register values
    task automatic send_directed();
        // balance 0 settles silently since 0 counts as already reported;
        // the very first delta is reported even though it is 0
        send_frame(compose_frame(32'd0,    1'b1, 32'd0, 8'd255, 1'b1, 32'd0, 8'd255));
        send_frame(compose_frame(32'd400,  1'b1, 32'd0, 8'd200, 1'b1, 32'd0, 8'd100));
        // balance change and delta change on one frame, conf minimum 0
        send_frame(compose_frame(32'd1000, 1'b1, 32'd5, 8'd0,   1'b1, 32'h8000_0000, 8'd255));
        send_frame(compose_frame(32'd1400, 1'b1, 32'd5, 8'd255, 1'b1, 32'h8000_0000, 8'd3));
        // repeats saturate the hit count; the last one brings a heartbeat
        send_frame(compose_frame(32'd3900, 1'b1, 32'd5, 8'd90,  1'b0, 32'h7FFF_FFFF, 8'd0));
        send_frame(compose_frame(32'd6400, 1'b1, 32'd5, 8'd91,  1'b0, 32'd0, 8'd0));
        send_frame(compose_frame(32'd8900, 1'b1, 32'd5, 8'd92,  1'b0, 32'd0, 8'd0));
        send_frame(compose_frame(32'd11400, 1'b1, 32'd5, 8'd93, 1'b0, 32'd0, 8'd0));
        // same time again: no second heartbeat
        send_frame(compose_frame(32'd11400, 1'b0, 32'hFFFF_FFFF, 8'd1,
                                 1'b1, 32'h7FFF_FFFF, 8'd255));
        // balance gone stale: no heartbeat
        send_frame(compose_frame(32'd25000, 1'b0, 32'd0, 8'd0, 1'b0, 32'd0, 8'd0));
        // runs spanning the wrap of the time counter
        send_frame(compose_frame(32'hFFFF_FF00, 1'b1, 32'hFFFF_FFFF, 8'd128,
                                 1'b1, 32'h7FFF_FFFF, 8'd255));
        send_frame(compose_frame(32'h0000_0100, 1'b1, 32'hFFFF_FFFF, 8'd77,
                                 1'b1, 32'h7FFF_FFFF, 8'd254));
        send_frame(compose_frame(32'h0000_0180, 1'b1, 32'hFFFF_FFFF, 8'd255,
                                 1'b1, 32'h7FFF_FFFF, 8'd255));
        send_frame(compose_frame(32'hFFFF_FFFF, 1'b1, 32'd1, 8'd255, 1'b1, 32'd1, 8'd255));
        send_frame(compose_frame(32'hFFFF_FFFF, 1'b1, 32'd1, 8'd0, 1'b1, 32'd1, 8'd0));
        frame_clock = 32'hFFFF_FFFF;
    endtask

    // random frames: persistent target values with noise and dropouts
    task automatic run_phase(input int settle, input int beat, input int fresh,
                             input int step_max, input int frames);
        t_frame f;
        int     r;
        wait_for_drain();
        write_settings(settle, beat, fresh);
        for (int n = 0; n < frames; n++) begin
            r = $urandom_range(0, 99);
            if (r == 0)
                frame_clock = frame_clock + $urandom();
            else if (r > 4)
                frame_clock = frame_clock + $urandom_range(0, step_max);
            if ($urandom_range(0, 7) == 0) bal_target = pick_reading();
            if ($urandom_range(0, 7) == 0) dlt_target = pick_reading();
            f.time_ms   = frame_clock;
            f.bal_valid = ($urandom_range(0, 9) != 0);
            f.bal_value = ($urandom_range(0, 9) == 0) ? pick_reading() : bal_target;
            f.bal_conf  = CONF_W'($urandom_range(0, 255));
            f.dlt_valid = ($urandom_range(0, 9) != 0);
            f.dlt_value = ($urandom_range(0, 9) == 0) ? pick_reading() : dlt_target;
            f.dlt_conf  = CONF_W'($urandom_range(0, 255));
            send_frame(f);
            if ($urandom_range(0, 149) == 0) wait_for_drain();
        end
    endtask

    // report sink with random stalls
    initial begin
        t_event got;
        int     stall;
        report_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait(sink_calm);
            if (stall > 0) begin
                report_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            report_bus.ready <= 1'b1;
            do @(posedge i_clk); while (report_bus.valid !== 1'b1);
            got.kind         = report_bus.event_kind;
            got.is_heartbeat = report_bus.is_heartbeat;
            got.time_ms      = report_bus.event_time;
            got.value        = report_bus.event_value;
            got.conf         = report_bus.event_conf;
            got.last_of_run  = report_bus.last_of_run;
            ledger.check_event(got);
        end
    end

    // main sequence
    initial begin
        ledger      = new();
        sender_calm = 0;
        sink_calm   = 0;
        frame_clock = '0;
        bal_target  = '0;
        dlt_target  = '0;

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_SETTLE_MS;
        i_cfg_data          <= '0;
        frame_bus.valid     <= 1'b0;
        frame_bus.time_ms   <= '0;
        frame_bus.bal_valid <= 1'b0;
        frame_bus.bal_value <= '0;
        frame_bus.bal_conf  <= '0;
        frame_bus.dlt_valid <= 1'b0;
        frame_bus.dlt_value <= '0;
        frame_bus.dlt_conf  <= '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();

        // heartbeat on every frame without a change report while the balance is fresh
        run_phase(0, 0, 65535, 60, 300);
        // widest settle and heartbeat, no freshness window
        run_phase(65535, 1048575, 0, 40000, 300);
        run_phase(300, 10000, 3000, 1500, 300);
        run_phase(100, 400, 2000, 150, 300);
        run_phase($urandom_range(0, 2000), $urandom_range(0, 6000),
                  $urandom_range(0, 8000), 900, 350);
        run_phase($urandom_range(0, 65535), $urandom_range(0, 1048575),
                  $urandom_range(0, 65535), 30000, 350);

        wait_for_drain();
        if (ledger.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
